// ===== src/kcd_pkg.sv =====
`default_nettype none
package kcd_pkg;

	localparam int MAX_KEYS   = 4;
	localparam int KEY_BITS   = 8;
	localparam int NUM_CHORDS = 8;

	localparam int CHORD_REGS = 8;
	localparam int CHORD_W    = 32;
	localparam int CFG_IDX_W  = $clog2(CHORD_REGS);
	localparam int KEY_CODE_W = 8;
	localparam int INDEX_W    = 3;
	localparam int COUNT_W    = 3;

	localparam int SLOT_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int TOTAL_W = $clog2(MAX_KEYS + 1);
	localparam int PACK_W = MAX_KEYS * KEY_BITS;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CHORD_W-1:0]  chord_t;

	typedef enum logic {
		REQ_PRESS   = 1'b0,
		REQ_RELEASE = 1'b1
	} req_kind_t;

endpackage
`default_nettype wire

// ===== src/kcd_if.sv =====
`default_nettype none
interface kcd_req_if;
	logic                            valid;
	logic                            ready;
	logic                            req_type;
	logic [kcd_pkg::KEY_CODE_W-1:0]  key_code;

	modport source (output valid, output req_type, output key_code, input ready);
	modport sink   (input valid, input req_type, input key_code, output ready);
endinterface

interface kcd_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          chord_hit;
	logic [kcd_pkg::INDEX_W-1:0]   chord_index;
	logic [kcd_pkg::COUNT_W-1:0]   held_count;
	logic [kcd_pkg::CHORD_W-1:0]   chord_code;
	logic                          press_dropped;

	modport source (output valid, output chord_hit, output chord_index, output held_count,
		output chord_code, output press_dropped, input ready);
	modport sink   (input valid, input chord_hit, input chord_index, input held_count,
		input chord_code, input press_dropped, output ready);
endinterface
`default_nettype wire

// ===== src/key_chord_detector_unit.sv =====
// Key chord detector: tracks up to four held keys and matches the sorted chord.
// The result is registered and becomes valid in the cycle after the input transfer.
// Throughput: one event per cycle while results are taken; set update, sort and chord compare are combinational.
// Output register decouples sides: input is taken while a result waits if it is taken too.
// Reset (arst_n low, asynchronous): held set empty, chord registers zero, no result pending.
`default_nettype none
module key_chord_detector_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	kcd_req_if.sink                            req,
	kcd_rsp_if.source                          rsp,
	input  wire logic                          cfg_we,
	input  wire logic [kcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [kcd_pkg::CHORD_W-1:0]   cfg_data
);
	import kcd_pkg::*;

	chord_t              chord_q [CHORD_REGS];
	key_t                held_keys_q [MAX_KEYS];
	logic [TOTAL_W-1:0]  held_total_q;

	logic                rsp_valid_q;
	logic                chord_hit_q;
	logic [INDEX_W-1:0]  chord_index_q;
	logic [COUNT_W-1:0]  held_count_q;
	chord_t              chord_code_q;
	logic                press_dropped_q;

	logic                accept;
	key_t                key;
	logic [KEY_BITS+KEY_CODE_W-1:0] key_ext;
	logic [MAX_KEYS-1:0] match;
	logic [SLOT_W-1:0]   rel_idx;
	logic [SLOT_W-1:0]   last_idx;
	logic                full;
	key_t                keys_n [MAX_KEYS];
	logic [TOTAL_W-1:0]  total_n;
	logic                dropped;
	key_t                srt [MAX_KEYS];
	key_t                tmp_swap;
	logic [PACK_W-1:0]   packed_keys;
	logic [PACK_W+CHORD_W-1:0] packed_ext;
	chord_t              code;
	logic                hit;
	logic [INDEX_W-1:0]  hit_idx;
	logic [TOTAL_W+COUNT_W-1:0] total_ext;

	assign accept    = req.valid && req.ready;
	assign req.ready = !rsp_valid_q || rsp.ready;

	assign key_ext = {{KEY_BITS{1'b0}}, req.key_code};
	assign key     = key_ext[KEY_BITS-1:0];

	always_comb begin
		match   = '0;
		rel_idx = '0;
		for (int i = MAX_KEYS - 1; i >= 0; i--) begin
			if ((TOTAL_W'(i) < held_total_q) && (held_keys_q[i] == key)) begin
				match[i] = 1'b1;
				rel_idx  = SLOT_W'(i);
			end
		end
	end

	assign full     = held_total_q >= TOTAL_W'(MAX_KEYS);
	assign last_idx = SLOT_W'(held_total_q - 1'b1);

	always_comb begin
		keys_n  = held_keys_q;
		total_n = held_total_q;
		dropped = 1'b0;
		if (req.req_type == REQ_PRESS) begin
			if (full) begin
				dropped = 1'b1;
			end else if (!(|match)) begin
				keys_n[SLOT_W'(held_total_q)] = key;
				total_n = held_total_q + 1'b1;
			end
		end else if (|match) begin
			keys_n[rel_idx]  = held_keys_q[last_idx];
			keys_n[last_idx] = '0;
			total_n = held_total_q - 1'b1;
		end
	end

	// odd-even transposition sort, descending
	always_comb begin
		tmp_swap = '0;
		for (int i = 0; i < MAX_KEYS; i++) begin
			srt[i] = (TOTAL_W'(i) < total_n) ? keys_n[i] : '0;
		end
		for (int r = 0; r < MAX_KEYS; r++) begin
			for (int i = 0; i < MAX_KEYS - 1; i++) begin
				if ((i[0] == r[0]) && (srt[i] < srt[i+1])) begin
					tmp_swap  = srt[i];
					srt[i]    = srt[i+1];
					srt[i+1]  = tmp_swap;
				end
			end
		end
		for (int i = 0; i < MAX_KEYS; i++) begin
			packed_keys[(MAX_KEYS-1-i)*KEY_BITS +: KEY_BITS] = srt[i];
		end
	end

	assign packed_ext = {{CHORD_W{1'b0}}, packed_keys};
	assign code       = packed_ext[CHORD_W-1:0];

	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int c = NUM_CHORDS - 1; c >= 0; c--) begin
			if ((chord_q[c] != '0) && (chord_q[c] == code)) begin
				hit     = 1'b1;
				hit_idx = INDEX_W'(c);
			end
		end
		if ((req.req_type != REQ_PRESS) || dropped) begin
			hit     = 1'b0;
			hit_idx = '0;
		end
	end

	assign total_ext = {{COUNT_W{1'b0}}, total_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHORD_REGS; c++) begin
				chord_q[c] <= '0;
			end
			for (int i = 0; i < MAX_KEYS; i++) begin
				held_keys_q[i] <= '0;
			end
			held_total_q <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				chord_q[cfg_index] <= cfg_data;
			end
			if (accept) begin
				held_keys_q  <= keys_n;
				held_total_q <= total_n;
				rsp_valid_q  <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chord_hit_q     <= hit;
			chord_index_q   <= hit_idx;
			held_count_q    <= total_ext[COUNT_W-1:0];
			chord_code_q    <= code;
			press_dropped_q <= dropped;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.chord_hit     = chord_hit_q;
	assign rsp.chord_index   = chord_index_q;
	assign rsp.held_count    = held_count_q;
	assign rsp.chord_code    = chord_code_q;
	assign rsp.press_dropped = press_dropped_q;

endmodule
`default_nettype wire
